[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
  `ASSERT_CLK(name, clk, rst, !(cond), msg)

`endif

[hdl/ipg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ipg_pkg;

  // Configuration
  localparam int             DIM_W           = 7;
  localparam int             MAX_DIM_DEFAULT = 64;
  localparam logic [DIM_W-1:0] DIM_RESET     = 7'd8;

  // Nearest double to 2.3 as a 53-bit mantissa (value * 2^51), split in two
  localparam logic [20:0] CELL_M_HI = 21'h126666;
  localparam logic [31:0] CELL_M_LO = 32'h66666666;

  // Colour scaling: hue = d*360, sat = (d*60+40)*255/100, light = sum*25*255/100
  localparam logic [8:0]  HUE_MUL   = 9'd360;
  localparam logic [13:0] SAT_MUL   = 14'd15300;
  localparam logic [47:0] SAT_ADD   = 48'd10200 << 31;
  localparam logic [12:0] LIGHT_MUL = 13'd6375;
  // ceil(2^24 / 100): exact quotient by 100 for values below 199728
  localparam logic [17:0] RECIP_100 = 18'd167773;

  typedef enum logic [1:0] {
    FUNC_ABSORB = 2'd0,
    FUNC_COLOR  = 2'd1,
    FUNC_ROW    = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ACC_HUE   = 2'd0,
    ACC_SAT   = 2'd1,
    ACC_FIRST = 2'd2,
    ACC_MORE  = 2'd3
  } acc_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_STEP,
    ST_ROUND,
    ST_ACC,
    ST_CMATH,
    ST_CDIV,
    ST_EMIT,
    ST_CMUL,
    ST_CELL,
    ST_RD,
    ST_OUT
  } ipg_state_t;

  typedef struct packed {
    logic     take;
    logic     absorb;
    logic     step;
    logic     round;
    logic     acc;
    acc_sel_t acc_sel;
    logic     color_mul;
    logic     color_div;
    logic     cell_mul;
    logic     cell_write;
    logic     read;
    logic     load;
    func_t    kind;
    logic     last;
  } ipg_cmd_t;

  typedef struct packed {
    logic out_free;
  } ipg_status_t;

endpackage

`default_nettype wire

[hdl/ipg_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/ipg_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ipg_ctrl #(
  parameter int MAX_DIM = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [6:0]              cfg_data,
  input  wire logic                    item_valid,
  output logic                         item_stall,
  input  wire logic [1:0]              func,
  input  wire ipg_pkg::ipg_status_t    status,
  output ipg_pkg::ipg_cmd_t            cmd,
  output logic [((MAX_DIM / 2 > 1) ? $clog2(MAX_DIM / 2) : 1)-1:0] idx
);

  import ipg_pkg::*;

  localparam int HALF_MAX = MAX_DIM / 2;
  localparam int CNT_W    = $clog2(HALF_MAX + 1);

  ipg_state_t       state;
  ipg_state_t       state_next;
  func_t            func_r;
  logic [2:0]       draw_cnt;
  logic             pass;
  logic [DIM_W-1:0] dimension;
  logic [5:0]       dim_half;
  logic [CNT_W-1:0] half;
  logic             last_idx;
  logic             accept;

  // Cells per half row, saturated at the RAM depth
  assign dim_half = dimension[DIM_W-1:1];
  assign half     = ({1'b0, dim_half} > 7'(HALF_MAX)) ? CNT_W'(HALF_MAX)
                                                      : dim_half[CNT_W-1:0];
  assign last_idx = (CNT_W'(idx) == half - CNT_W'(1));
  assign accept   = item_valid && (state == ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          case (func)
            FUNC_ABSORB: state_next = ST_ABSORB;
            FUNC_COLOR:  state_next = ST_STEP;
            FUNC_ROW:    state_next = (half == '0) ? ST_IDLE : ST_STEP;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_ABSORB: state_next = ST_EMIT;
      ST_STEP:   state_next = ST_ROUND;
      ST_ROUND:  state_next = (func_r == FUNC_COLOR) ? ST_ACC : ST_CMUL;
      ST_ACC:    state_next = (draw_cnt == 3'd5) ? ST_CMATH : ST_STEP;
      ST_CMATH:  state_next = ST_CDIV;
      ST_CDIV:   state_next = ST_EMIT;
      ST_EMIT:   state_next = status.out_free ? ST_IDLE : ST_EMIT;
      ST_CMUL:   state_next = ST_CELL;
      ST_CELL:   state_next = last_idx ? ST_RD : ST_STEP;
      ST_RD:     state_next = ST_OUT;
      ST_OUT: begin
        if (status.out_free) begin
          state_next = (pass && idx == '0) ? ST_IDLE : ST_RD;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd        = '0;
    item_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE:   cmd.take = item_valid;
      ST_ABSORB: cmd.absorb = 1'b1;
      ST_STEP:   cmd.step = 1'b1;
      ST_ROUND:  cmd.round = 1'b1;
      ST_ACC: begin
        cmd.acc = 1'b1;
        case (draw_cnt)
          3'd0:    cmd.acc_sel = ACC_HUE;
          3'd1:    cmd.acc_sel = ACC_SAT;
          3'd2:    cmd.acc_sel = ACC_FIRST;
          default: cmd.acc_sel = ACC_MORE;
        endcase
      end
      ST_CMATH:  cmd.color_mul = 1'b1;
      ST_CDIV:   cmd.color_div = 1'b1;
      ST_EMIT: begin
        cmd.load = status.out_free;
        cmd.kind = func_r;
        cmd.last = 1'b1;
      end
      ST_CMUL:   cmd.cell_mul = 1'b1;
      ST_CELL:   cmd.cell_write = 1'b1;
      ST_RD:     cmd.read = 1'b1;
      ST_OUT: begin
        cmd.load = status.out_free;
        cmd.kind = FUNC_ROW;
        cmd.last = pass && (idx == '0);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State, counters and the dimension register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      func_r    <= FUNC_ABSORB;
      draw_cnt  <= '0;
      idx       <= '0;
      pass      <= 1'b0;
      dimension <= DIM_RESET;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        dimension <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            func_r   <= func_t'(func);
            draw_cnt <= '0;
            idx      <= '0;
            pass     <= 1'b0;
          end
        end
        ST_ACC: draw_cnt <= draw_cnt + 3'd1;
        ST_CELL: begin
          // restart at the first cell for the forward replay
          idx <= last_idx ? '0 : idx + 1'b1;
        end
        ST_OUT: begin
          if (status.out_free) begin
            if (!pass) begin
              if (last_idx) begin
                pass <= 1'b1;
              end else begin
                idx <= idx + 1'b1;
              end
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        default: begin
          draw_cnt <= draw_cnt;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_load_when_free, clk, rst, cmd.load |-> status.out_free, "load into busy output")
  `ASSERT_CLK(a_idx_in_half, clk, rst, (state == ST_OUT) |-> (CNT_W'(idx) < half), "row index past half")
  `ASSERT_CLK(a_six_draws, clk, rst, (state == ST_CMATH) |-> (draw_cnt == 3'd6), "colour draw count off")

endmodule

`default_nettype wire

[hdl/ipg_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ipg_datapath #(
  parameter int MAX_DIM = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           seed_byte,
  input  wire ipg_pkg::ipg_cmd_t    cmd,
  input  wire logic [((MAX_DIM / 2 > 1) ? $clog2(MAX_DIM / 2) : 1)-1:0] idx,
  output ipg_pkg::ipg_status_t      status,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output logic [1:0]                kind,
  output logic [9:0]                hue,
  output logic [8:0]                saturation,
  output logic [8:0]                lightness,
  output logic [2:0]                cell_res,
  output logic                      last
);

  import ipg_pkg::*;

  localparam int HALF_MAX = MAX_DIM / 2;
  localparam int IDX_W    = (HALF_MAX > 1) ? $clog2(HALF_MAX) : 1;

  logic [31:0] seed_words [4];
  logic [1:0]  seed_position;
  logic [7:0]  byte_r;

  logic [31:0] s0;
  logic [31:0] s3;
  logic [31:0] t;
  logic [31:0] u_new;
  logic [31:0] cur_word;
  logic [31:0] absorbed;

  logic [31:0] u;
  logic [3:0]  sh;
  logic [3:0]  sh_m1;
  logic [31:0] u_g;
  logic [31:0] u_mask;
  logic [24:0] q_pre;
  logic        round_up;
  logic [24:0] q_r;
  logic [3:0]  s_r;
  logic [32:0] f_cur;

  logic [32:0] fh;
  logic [32:0] fs;
  logic [34:0] fsum;
  logic [41:0] hue_prod;
  logic [47:0] sat_prod;
  logic [47:0] light_prod;
  logic [9:0]  hue_r;
  logic [15:0] sat_z;
  logic [15:0] light_z;
  logic [33:0] sat_q;
  logic [33:0] light_q;
  logic [8:0]  sat_r;
  logic [8:0]  light_r;

  logic [56:0] r_lo;
  logic [45:0] r_hi;
  logic [77:0] prod;
  logic [85:0] scaled;
  logic [2:0]  k;
  logic        bump;
  logic [2:0]  cell_code;
  logic [2:0]  ram_q;

  // xorshift128 step
  always_comb begin
    s0    = seed_words[0];
    s3    = seed_words[3];
    t     = s0 ^ (s0 << 11);
    u_new = s3 ^ {{19{s3[31]}}, s3[31:19]} ^ t ^ {{8{t[31]}}, t[31:8]};
  end

  // word * 31 + sign-extended byte
  assign cur_word = seed_words[seed_position];
  assign absorbed = (cur_word << 5) - cur_word + {{24{byte_r[7]}}, byte_r};

  // Round word 3 to a 24-bit mantissa, nearest even
  always_comb begin
    u  = seed_words[3];
    sh = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (u[24 + i]) begin
        sh = 4'(i + 1);
      end
    end
    sh_m1    = sh - 4'd1;
    u_g      = u >> sh_m1;
    u_mask   = (32'd1 << sh_m1) - 32'd1;
    q_pre    = 25'(u >> sh);
    round_up = (sh != 4'd0) && u_g[0] && ((|(u & u_mask)) || q_pre[0]);
  end

  assign f_cur = 33'(q_r) << s_r;

  // Colour scaling products
  assign hue_prod   = 42'(fh) * 42'(HUE_MUL);
  assign sat_prod   = 48'(fs) * 48'(SAT_MUL) + SAT_ADD;
  assign light_prod = 48'(fsum) * 48'(LIGHT_MUL);
  assign sat_q      = 34'(sat_z) * 34'(RECIP_100);
  assign light_q    = 34'(light_z) * 34'(RECIP_100);

  // Cell code: floor of the double-rounded product d * 2.3
  always_comb begin
    prod   = {r_hi, 32'b0} + 78'(r_lo);
    scaled = 86'(prod) << s_r;
    k      = scaled[84:82];
    case (k)
      3'd0:    bump = &scaled[81:28];
      3'd1:    bump = &scaled[81:29];
      default: bump = &scaled[81:30];
    endcase
    cell_code = k + 3'(bump);
  end

  // Seed state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        seed_words[i] <= '0;
      end
      seed_position <= '0;
    end else if (cmd.absorb) begin
      seed_words[seed_position] <= absorbed;
      seed_position             <= seed_position + 2'd1;
    end else if (cmd.step) begin
      seed_words[0] <= seed_words[1];
      seed_words[1] <= seed_words[2];
      seed_words[2] <= s3;
      seed_words[3] <= u_new;
    end
  end

  // Draw and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_r <= seed_byte;
    end
    if (cmd.round) begin
      q_r <= q_pre + 25'(round_up);
      s_r <= sh;
    end
    if (cmd.acc) begin
      case (cmd.acc_sel)
        ACC_HUE:   fh   <= f_cur;
        ACC_SAT:   fs   <= f_cur;
        ACC_FIRST: fsum <= 35'(f_cur);
        ACC_MORE:  fsum <= fsum + 35'(f_cur);
        default:   fsum <= fsum;
      endcase
    end
    if (cmd.color_mul) begin
      hue_r   <= hue_prod[40:31];
      sat_z   <= sat_prod[46:31];
      light_z <= light_prod[46:31];
    end
    if (cmd.color_div) begin
      sat_r   <= sat_q[32:24];
      light_r <= light_q[32:24];
    end
    if (cmd.cell_mul) begin
      r_lo <= 57'(q_r) * 57'(CELL_M_LO);
      r_hi <= 46'(q_r) * 46'(CELL_M_HI);
    end
  end

  ipg_ram #(
    .WIDTH (3),
    .DEPTH (HALF_MAX)
  ) u_half_row (
    .clk   (clk),
    .we    (cmd.cell_write),
    .waddr (IDX_W'(idx)),
    .wdata (cell_code),
    .re    (cmd.read),
    .raddr (IDX_W'(idx)),
    .rdata (ram_q)
  );

  // Output word register
  assign status.out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= cmd.kind;
      last <= cmd.last;
      case (cmd.kind)
        FUNC_COLOR: begin
          hue        <= hue_r;
          saturation <= sat_r;
          lightness  <= light_r;
          cell_res   <= '0;
        end
        FUNC_ROW: begin
          hue        <= '0;
          saturation <= '0;
          lightness  <= '0;
          cell_res   <= ram_q;
        end
        default: begin
          hue        <= '0;
          saturation <= '0;
          lightness  <= '0;
          cell_res   <= '0;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_load_shows, clk, rst, cmd.load |=> res_valid, "loaded word not shown")
  `ASSERT_NEVER(a_row_clean, clk, rst, res_valid && kind == FUNC_ROW && (hue != '0 || saturation != '0 || lightness != '0), "row word carries colour")
  `ASSERT_CLK(a_seed_advance, clk, rst, cmd.absorb |=> (seed_position == $past(seed_position) + 2'd1), "seed position did not advance")

endmodule

`default_nettype wire

[hdl/identicon_pattern_generator.sv]
// Identicon pattern generator: xorshift128 seeded from address bytes.
// Input channel (item_valid / item_stall, func, seed_byte): a word is taken
// when item_valid is high and item_stall is low; item_stall is low only
// while the block is idle. func 0 absorbs a seed byte, 1 draws a colour,
// 2 emits one mirrored row of cells, 3 is taken and dropped.
// Result channel (res_valid / res_stall): one output register; a word is
// taken when res_valid is high and res_stall is low. While the receiver
// stalls the word holds and the block waits at its next load.
// From accept to the output register: absorb updates a seed word, then
// loads; colour runs six draws (step, round, accumulate), then scaling
// (multiply, divide), then loads; row draws each half-row cell (step,
// round, multiply, code), then reads and loads 2*half output cells,
// half = min(dimension/2, MAX_DIM/2). Throughput is set by the shared
// draw unit (step, round, multiply, code) and the single read port of
// the half-row RAM. cfg_write loads dimension from cfg_data; the user
// must write it only while the block is idle, which the block does not
// enforce. Synchronous reset clears the seed words, seed position and
// output valid and sets dimension to 8; the half-row RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module identicon_pattern_generator #(
  parameter int MAX_DIM = ipg_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [6:0] cfg_data,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [1:0] func,
  input  wire logic [7:0] seed_byte,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic [1:0]      kind,
  output logic [9:0]      hue,
  output logic [8:0]      saturation,
  output logic [8:0]      lightness,
  output logic [2:0]      cell_res,
  output logic            last
);

  import ipg_pkg::*;

  localparam int HALF_MAX = MAX_DIM / 2;
  localparam int IDX_W    = (HALF_MAX > 1) ? $clog2(HALF_MAX) : 1;

  ipg_cmd_t         cmd;
  ipg_status_t      status;
  logic [IDX_W-1:0] idx;

  ipg_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .func       (func),
    .status     (status),
    .cmd        (cmd),
    .idx        (idx)
  );

  ipg_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .seed_byte  (seed_byte),
    .cmd        (cmd),
    .idx        (idx),
    .status     (status),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .kind       (kind),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .cell_res   (cell_res),
    .last       (last)
  );

endmodule

`default_nettype wire
